// ===== src/rms_prof_pkg.sv =====
// Package for the read memory size profiler: operation codes, controller
// states, datapath command and status structs. No dependencies.
package rms_prof_pkg;

	localparam int DefStackDepth = 64;
	localparam int DefAddressBits = 16;

	localparam int StampW = 32;
	localparam int RmsW = 48;
	localparam int CostW = 48;
	localparam int FuncW = 32;

	typedef enum logic [2:0] {
		OP_CALL = 3'd0,
		OP_RETURN = 3'd1,
		OP_READ = 3'd2,
		OP_WRITE = 3'd3,
		OP_ADD_RMS = 3'd4
	} op_t;

	typedef enum logic [3:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_DISPATCH,
		ST_BYTE_RD,
		ST_BYTE_CHK,
		ST_WALK_RD,
		ST_WALK_CHK,
		ST_RET_RD,
		ST_RET_FOLD,
		ST_EMIT
	} state_t;

	typedef struct packed {
		logic clr_step;    // write zero at clear address, advance
		logic load;        // capture the input beat
		logic push;        // call
		logic add_rms;     // add length to top rms
		logic byte_rd;     // read stamp and top frame
		logic byte_upd;    // write stamp, bump top rms, load walk index
		logic walk_rd;     // read frame at walk index
		logic walk_dec;    // lower rms at walk index
		logic walk_next;   // step walk index down
		logic next_byte;   // advance byte address, decrement count
		logic ret_rd;      // read top frame and caller
		logic ret_fold;    // form record, fold into caller, pop
	} dp_cmd_t;

	typedef struct packed {
		logic clr_done;
		logic [2:0] op;
		logic stack_full;
		logic stack_empty;
		logic count_zero;
		logic old_older;   // old stamp predates top frame
		logic old_nonzero;
		logic walk_hit;    // frame start at or below old stamp
		logic walk_zero;   // walk index reached the sentinel
	} dp_stat_t;

endpackage

// ===== src/rms_prof_ctrl.sv =====
// Controller of the read memory size profiler: sequences events over the
// datapath. Depends on rms_prof_pkg.
module rms_prof_ctrl (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   enable,
	input  logic                   in_valid,
	output logic                   in_ready,
	output logic                   out_valid,
	input  logic                   out_ready,
	input  rms_prof_pkg::dp_stat_t stat,
	output rms_prof_pkg::dp_cmd_t  cmd
);
	import rms_prof_pkg::*;

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_CLEAR: begin
				if (stat.clr_done) state_d = ST_IDLE;
			end
			ST_IDLE: begin
				if (in_valid) state_d = enable ? ST_DISPATCH : ST_IDLE;
			end
			ST_DISPATCH: begin
				priority case (stat.op)
					OP_RETURN: state_d = stat.stack_empty ? ST_IDLE : ST_RET_RD;
					OP_READ, OP_WRITE: state_d = stat.count_zero ? ST_IDLE : ST_BYTE_RD;
					default: state_d = ST_IDLE;
				endcase
			end
			ST_BYTE_RD: state_d = ST_BYTE_CHK;
			ST_BYTE_CHK: begin
				if (stat.op == OP_READ && stat.old_older && stat.old_nonzero
						&& !stat.walk_zero) begin
					state_d = ST_WALK_RD;
				end else if (stat.count_zero) begin
					state_d = ST_IDLE;
				end else begin
					state_d = ST_BYTE_RD;
				end
			end
			ST_WALK_RD: state_d = ST_WALK_CHK;
			ST_WALK_CHK: begin
				if (stat.walk_hit || stat.walk_zero) begin
					state_d = stat.count_zero ? ST_IDLE : ST_BYTE_RD;
				end else begin
					state_d = ST_WALK_RD;
				end
			end
			ST_RET_RD: state_d = ST_RET_FOLD;
			ST_RET_FOLD: state_d = ST_EMIT;
			ST_EMIT: begin
				if (out_ready) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd = '0;
		in_ready = 1'b0;
		out_valid = 1'b0;
		unique case (state_q)
			ST_CLEAR: cmd.clr_step = 1'b1;
			ST_IDLE: begin
				in_ready = 1'b1;
				cmd.load = in_valid && enable;
			end
			ST_DISPATCH: begin
				cmd.push = (stat.op == OP_CALL) && !stat.stack_full;
				cmd.add_rms = (stat.op == OP_ADD_RMS);
			end
			ST_BYTE_RD: cmd.byte_rd = 1'b1;
			ST_BYTE_CHK: begin
				cmd.byte_upd = 1'b1;
				cmd.next_byte = !(stat.op == OP_READ && stat.old_older
					&& stat.old_nonzero && !stat.walk_zero);
			end
			ST_WALK_RD: cmd.walk_rd = 1'b1;
			ST_WALK_CHK: begin
				cmd.walk_dec = stat.walk_hit;
				cmd.walk_next = !stat.walk_hit && !stat.walk_zero;
				cmd.next_byte = stat.walk_hit || stat.walk_zero;
			end
			ST_RET_RD: cmd.ret_rd = 1'b1;
			ST_RET_FOLD: cmd.ret_fold = 1'b1;
			ST_EMIT: out_valid = 1'b1;
			default: cmd = '0;
		endcase
	end

endmodule

// ===== src/rms_prof_dp.sv =====
// Datapath of the read memory size profiler: stamp memory, frame memories,
// stack pointer, call counter and byte walker. Depends on rms_prof_pkg.
module rms_prof_dp #(
	parameter int STACK_DEPTH = rms_prof_pkg::DefStackDepth,
	parameter int ADDRESS_BITS = rms_prof_pkg::DefAddressBits
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  rms_prof_pkg::dp_cmd_t           cmd,
	output rms_prof_pkg::dp_stat_t          stat,
	input  logic [2:0]                      in_op,
	input  logic [ADDRESS_BITS-1:0]         in_addr,
	input  logic [15:0]                     in_len,
	input  logic [rms_prof_pkg::FuncW-1:0]  in_func,
	input  logic [31:0]                     in_cost,
	output logic [rms_prof_pkg::FuncW-1:0]  rec_func,
	output logic [rms_prof_pkg::StampW-1:0] rec_start,
	output logic [rms_prof_pkg::RmsW-1:0]   rec_rms,
	output logic [rms_prof_pkg::CostW-1:0]  rec_cost
);
	import rms_prof_pkg::*;

	localparam int Frames = STACK_DEPTH + 1;
	localparam int SpW = $clog2(Frames);
	localparam int Words = 1 << ADDRESS_BITS;

	logic [StampW-1:0] stamp_mem [Words];
	logic [FuncW-1:0]  func_mem  [Frames];
	logic [StampW-1:0] start_mem [Frames];
	logic [RmsW-1:0]   rms_mem   [Frames];
	logic [CostW-1:0]  cost_mem  [Frames];

	logic [ADDRESS_BITS:0]   clr_q;
	logic [2:0]              op_q;
	logic [ADDRESS_BITS-1:0] addr_q;
	logic [15:0]             cnt_q;
	logic [FuncW-1:0]        func_q;
	logic [31:0]             cost_q;
	logic [SpW-1:0]          sp_q;
	logic [StampW-1:0]       ctr_q;
	logic [SpW-1:0]          walk_q;
	logic [StampW-1:0]       old_q;
	logic [StampW-1:0]       top_start_q;
	logic [StampW-1:0]       walk_start_q;
	logic [RmsW-1:0]         rd_rms_q;
	logic [CostW-1:0]        top_cost_q;
	logic [FuncW-1:0]        top_func_q;
	logic [RmsW-1:0]         call_rms_q;
	logic [CostW-1:0]        call_cost_q;
	logic [FuncW-1:0]        rec_func_q;
	logic [StampW-1:0]       rec_start_q;
	logic [RmsW-1:0]         rec_rms_q;
	logic [CostW-1:0]        rec_cost_q;

	logic [SpW-1:0] sp_dn;
	logic [SpW-1:0] rd_idx;
	logic [CostW-1:0] ret_cost;

	assign sp_dn = sp_q - 1'b1;
	assign ret_cost = top_cost_q + CostW'(cost_q);

	// one frame read port: top during byte, add and return, walk index during walk
	always_comb begin
		priority if (cmd.walk_rd) begin
			rd_idx = walk_q;
		end else begin
			rd_idx = sp_q;
		end
	end

	// stamp memory: clear sweep, swap per byte; hold the old stamp over the walk
	always_ff @(posedge clk) begin
		if (cmd.clr_step) begin
			stamp_mem[clr_q[ADDRESS_BITS-1:0]] <= '0;
		end else if (cmd.byte_upd) begin
			stamp_mem[addr_q] <= ctr_q;
		end
		if (cmd.byte_rd) begin
			old_q <= stamp_mem[addr_q];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q <= '0;
		end else if (cmd.clr_step && !clr_q[ADDRESS_BITS]) begin
			clr_q <= clr_q + 1'b1;
		end
	end

	// frame memories; sentinel entry written at clear
	always_ff @(posedge clk) begin
		if (cmd.clr_step) begin
			func_mem[0] <= '0;
			start_mem[0] <= '0;
			rms_mem[0] <= '0;
			cost_mem[0] <= '0;
		end else if (cmd.push) begin
			func_mem[SpW'(sp_q + 1'b1)] <= func_q;
			start_mem[SpW'(sp_q + 1'b1)] <= ctr_q + 1'b1;
			rms_mem[SpW'(sp_q + 1'b1)] <= '0;
			cost_mem[SpW'(sp_q + 1'b1)] <= '0;
		end else if (cmd.add_rms) begin
			rms_mem[sp_q] <= rd_rms_q + RmsW'(cnt_q);
		end else if (cmd.byte_upd && op_q == OP_READ && old_q < top_start_q) begin
			rms_mem[sp_q] <= rd_rms_q + 1'b1;
		end else if (cmd.walk_dec) begin
			rms_mem[walk_q] <= rd_rms_q - 1'b1;
		end else if (cmd.ret_fold) begin
			rms_mem[sp_dn] <= call_rms_q + rd_rms_q;
			cost_mem[sp_dn] <= call_cost_q + ret_cost;
		end
		top_start_q <= start_mem[sp_q];
		walk_start_q <= start_mem[walk_q];
		rd_rms_q <= rms_mem[rd_idx];
		top_cost_q <= cost_mem[sp_q];
		top_func_q <= func_mem[sp_q];
		call_rms_q <= rms_mem[sp_dn];
		call_cost_q <= cost_mem[sp_dn];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sp_q <= '0;
			ctr_q <= '0;
		end else if (cmd.push) begin
			sp_q <= sp_q + 1'b1;
			ctr_q <= ctr_q + 1'b1;
		end else if (cmd.ret_fold) begin
			sp_q <= sp_dn;
		end
	end

	// input beat and byte walker; add_rms reads top via rd_rms_q loaded at dispatch
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q <= in_op;
			addr_q <= in_addr;
			cnt_q <= in_len;
			func_q <= in_func;
			cost_q <= in_cost;
		end else if (cmd.next_byte) begin
			addr_q <= addr_q + 1'b1;
			cnt_q <= cnt_q - 1'b1;
		end
		if (cmd.byte_upd) begin
			walk_q <= sp_dn;
		end else if (cmd.walk_next) begin
			walk_q <= walk_q - 1'b1;
		end
		if (cmd.ret_fold) begin
			rec_func_q <= top_func_q;
			rec_start_q <= top_start_q;
			rec_rms_q <= rd_rms_q;
			rec_cost_q <= ret_cost;
		end
	end

	always_comb begin
		stat.clr_done = clr_q[ADDRESS_BITS];
		stat.op = op_q;
		stat.stack_full = (32'(sp_q) >= 32'(STACK_DEPTH));
		stat.stack_empty = (sp_q == '0);
		stat.count_zero = cmd.next_byte ? (cnt_q == 16'd1) : (cnt_q == '0);
		stat.old_older = (old_q < top_start_q);
		stat.old_nonzero = (old_q != '0);
		stat.walk_hit = (walk_start_q <= old_q);
		stat.walk_zero = cmd.byte_upd ? (sp_q == '0) : (walk_q == '0);
	end

	assign rec_func = rec_func_q;
	assign rec_start = rec_start_q;
	assign rec_rms = rec_rms_q;
	assign rec_cost = rec_cost_q;

endmodule

// ===== src/read_memory_size_profiler.sv =====
// Top level of the read memory size profiler: stream ports, controller and
// datapath. Depends on rms_prof_pkg, rms_prof_ctrl, rms_prof_dp.
//
// After reset the block sweeps its stamp memory, all 2^ADDRESS_BITS words
// (65536 by default), taking no event beat. Then one event at a time: a
// call, add rms, return on an empty stack or unknown event goes through
// dispatch back to idle; an event while recording is off is dropped in
// idle; a return reads the top frame and caller, folds into the caller,
// pops and waits on m_axis_tready; a read or write swaps each byte's stamp,
// and a read byte whose old stamp lies in an older frame walks the frames
// below the top. The enable register is written on cfg_valid/cfg_ready.
module read_memory_size_profiler #(
	parameter int STACK_DEPTH = rms_prof_pkg::DefStackDepth,
	parameter int ADDRESS_BITS = rms_prof_pkg::DefAddressBits
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         cfg_valid,
	output logic         cfg_ready,
	input  logic         cfg_data,
	input  logic         s_axis_tvalid,
	output logic         s_axis_tready,
	// address[15:0], length[31:16], func_id[63:32], cost[95:64]
	input  logic [95:0]  s_axis_tdata,
	// operation[2:0]
	input  logic [2:0]   s_axis_tuser,
	output logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	// rec_func_id[31:0], rec_start_time[63:32], rec_rms[111:64], rec_cost[159:112]
	output logic [159:0] m_axis_tdata
);
	import rms_prof_pkg::*;

	logic enable_q;
	dp_cmd_t cmd;
	dp_stat_t stat;
	logic [FuncW-1:0] rec_func;
	logic [StampW-1:0] rec_start;
	logic [RmsW-1:0] rec_rms;
	logic [CostW-1:0] rec_cost;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			enable_q <= 1'b0;
		end else if (cfg_valid) begin
			enable_q <= cfg_data;
		end
	end

	rms_prof_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.enable    (enable_q),
		.in_valid  (s_axis_tvalid),
		.in_ready  (s_axis_tready),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.stat      (stat),
		.cmd       (cmd)
	);

	rms_prof_dp #(
		.STACK_DEPTH  (STACK_DEPTH),
		.ADDRESS_BITS (ADDRESS_BITS)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.stat      (stat),
		.in_op     (s_axis_tuser),
		.in_addr   (ADDRESS_BITS'(s_axis_tdata[15:0])),
		.in_len    (s_axis_tdata[31:16]),
		.in_func   (s_axis_tdata[63:32]),
		.in_cost   (s_axis_tdata[95:64]),
		.rec_func  (rec_func),
		.rec_start (rec_start),
		.rec_rms   (rec_rms),
		.rec_cost  (rec_cost)
	);

	assign m_axis_tdata = {rec_cost, rec_rms, rec_start, rec_func};

endmodule
